>>> src/periodic_boundary_image_generator_assert.svh
// ----------------------------------------------------------------------------
// periodic boundary image generator assertion macros
// shared property shapes for the checker, clocked on clk, quiet in reset
// ----------------------------------------------------------------------------
`ifndef PERIODIC_BOUNDARY_IMAGE_GENERATOR_ASSERT_SVH
`define PERIODIC_BOUNDARY_IMAGE_GENERATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define PBIG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define PBIG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/pbig_pkg.sv
// ----------------------------------------------------------------------------
// pbig_pkg
// shared widths, register indexes and the lattice shift table
// ----------------------------------------------------------------------------
package pbig_pkg;

  localparam int MAX_IMAGES  = 26;
  localparam int COORD_WIDTH = 21;

  localparam int NUM_SHIFTS  = 26;
  localparam int NUM_AXES    = 3;
  localparam int POS_W       = 21;
  localparam int FRAC_W      = 20;
  localparam int ROW_W       = 63;
  localparam int ID_W        = 32;
  localparam int THR_W       = 17;
  localparam int CFG_W       = 63;
  localparam int CFG_IDX_W   = 3;
  localparam int SHIFT_IDX_W = $clog2(NUM_SHIFTS);
  localparam int AXIS_W      = 2;
  localparam int CNT_W       = $clog2(MAX_IMAGES + 1);
  localparam int FRAC_ONE    = 65536;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(6554);
  localparam logic [ID_W-1:0]  ID_RESET  = ID_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE     = 3'd0,
    REG_THRESHOLD  = 3'd1,
    REG_ROW_A      = 3'd2,
    REG_ROW_B      = 3'd3,
    REG_ROW_C      = 3'd4,
    REG_FIRST_ID   = 3'd5
  } reg_index_t;

  // per axis direction of one lattice shift, bit 0 is axis a
  typedef struct packed {
    logic [NUM_AXES-1:0] pos;
    logic [NUM_AXES-1:0] neg;
  } shift_dir_t;

  // faces, then edges, then corners
  localparam shift_dir_t SHIFT_TABLE [NUM_SHIFTS] = '{
    '{3'b001, 3'b000}, '{3'b000, 3'b001}, '{3'b010, 3'b000}, '{3'b000, 3'b010},
    '{3'b100, 3'b000}, '{3'b000, 3'b100},
    '{3'b011, 3'b000}, '{3'b001, 3'b010}, '{3'b010, 3'b001}, '{3'b000, 3'b011},
    '{3'b110, 3'b000}, '{3'b010, 3'b100}, '{3'b100, 3'b010}, '{3'b000, 3'b110},
    '{3'b101, 3'b000}, '{3'b001, 3'b100}, '{3'b100, 3'b001}, '{3'b000, 3'b101},
    '{3'b111, 3'b000}, '{3'b011, 3'b100}, '{3'b101, 3'b010}, '{3'b001, 3'b110},
    '{3'b110, 3'b001}, '{3'b010, 3'b101}, '{3'b100, 3'b011}, '{3'b000, 3'b111}
  };

endpackage

>>> src/periodic_boundary_image_generator.sv
// ----------------------------------------------------------------------------
// periodic_boundary_image_generator
// emits the periodic images of an atom lying near the faces of its cell
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) takes one atom per beat with its cartesian
//   and fractional coordinates; output channel (out_valid/out_ready) gives one
//   image per beat, last_image set on the final image of that atom.
//   registers are written through cfg_we/cfg_index/cfg_data; the user must do
//   so only while idle, which the block does not enforce. writing first_image_id
//   reloads the running image id counter.
// operation:
//   one shared axis unit builds an image axis by axis in ST_CALC, then ST_PUSH
//   moves it into the output register. a skipped atom never leaves idle; an atom
//   that needs no image passes through ST_CALC back to idle. in_ready is low
//   while an atom is being worked on.
// stalls and reset:
//   while out_ready is low the output register holds and the sequencer waits
//   with the next image; a new atom is accepted while the final image of the
//   previous one still waits. rst (synchronous) clears the registers to their
//   reset values and empties the output register.
// ----------------------------------------------------------------------------
module periodic_boundary_image_generator import pbig_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [ID_W-1:0]          atom_id,
  input  logic                     is_boundary,
  input  logic signed [POS_W-1:0]  pos_x,
  input  logic signed [POS_W-1:0]  pos_y,
  input  logic signed [POS_W-1:0]  pos_z,
  input  logic signed [FRAC_W-1:0] cell_frac_a,
  input  logic signed [FRAC_W-1:0] cell_frac_b,
  input  logic signed [FRAC_W-1:0] cell_frac_c,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [ID_W-1:0]          image_id,
  output logic [ID_W-1:0]          source_id,
  output logic signed [POS_W-1:0]  image_x,
  output logic signed [POS_W-1:0]  image_y,
  output logic signed [POS_W-1:0]  image_z,
  output logic signed [FRAC_W-1:0] image_frac_a,
  output logic signed [FRAC_W-1:0] image_frac_b,
  output logic signed [FRAC_W-1:0] image_frac_c,
  output logic                     last_image
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

  localparam int CMP_W = FRAC_W + 2;
  localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(NUM_AXES - 1);
  localparam logic signed [CMP_W-1:0] CMP_ONE = CMP_W'(FRAC_ONE);

  // configuration
  logic                enable;
  logic [THR_W-1:0]    edge_threshold;
  logic [ROW_W-1:0]    cell_row_a;
  logic [ROW_W-1:0]    cell_row_b;
  logic [ROW_W-1:0]    cell_row_c;
  logic [ID_W-1:0]     next_image_id;

  // control
  state_t              state;
  logic [NUM_SHIFTS-1:0] pending;
  logic [CNT_W-1:0]    count;
  logic [AXIS_W-1:0]   axis;

  // atom and image payload
  logic [ID_W-1:0]          src_id;
  logic signed [POS_W-1:0]  pos_q [NUM_AXES];
  logic signed [FRAC_W-1:0] frac_q [NUM_AXES];
  logic signed [POS_W-1:0]  img_pos_q [NUM_AXES];
  logic signed [FRAC_W-1:0] img_frac_q [NUM_AXES];

  // combinational
  logic                     in_fire;
  logic                     skip;
  logic                     push_go;
  logic                     last_next;
  logic signed [FRAC_W-1:0] frac_in [NUM_AXES];
  logic [NUM_AXES-1:0]      need_pos;
  logic [NUM_AXES-1:0]      need_neg;
  logic [NUM_SHIFTS-1:0]    take;
  logic [NUM_SHIFTS-1:0]    sel_oh;
  logic [SHIFT_IDX_W-1:0]   sel;
  shift_dir_t               dir;
  logic signed [CMP_W-1:0]  thr_s;
  logic signed [CMP_W-1:0]  neg_lim;
  logic signed [CMP_W-1:0]  frac_s;
  logic signed [POS_W-1:0]  unit_pos;
  logic signed [FRAC_W-1:0] unit_frac;

  function automatic logic signed [POS_W-1:0] row_comp(
    input logic [ROW_W-1:0]  row,
    input logic [AXIS_W-1:0] k
  );
    case (k)
      2'd0:    return $signed(row[POS_W*0 +: POS_W]);
      2'd1:    return $signed(row[POS_W*1 +: POS_W]);
      2'd2:    return $signed(row[POS_W*2 +: POS_W]);
      default: return '0;
    endcase
  endfunction

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign skip     = !enable || is_boundary || (atom_id == '0);
  assign push_go  = (state == ST_PUSH) && (!out_valid || out_ready);

  // face tests and shift selection
  always_comb begin
    frac_in[0] = cell_frac_a;
    frac_in[1] = cell_frac_b;
    frac_in[2] = cell_frac_c;
    thr_s   = $signed({{(CMP_W-THR_W){1'b0}}, edge_threshold});
    neg_lim = CMP_ONE - thr_s;
    for (int k = 0; k < NUM_AXES; k++) begin
      frac_s = $signed({{(CMP_W-FRAC_W){frac_in[k][FRAC_W-1]}}, frac_in[k]});
      need_pos[k] = (frac_s <= thr_s);
      need_neg[k] = (frac_s >= neg_lim);
    end
    for (int s = 0; s < NUM_SHIFTS; s++) begin
      take[s] = (&(~SHIFT_TABLE[s].pos | need_pos)) && (&(~SHIFT_TABLE[s].neg | need_neg));
    end
  end

  // lowest pending shift
  always_comb begin
    sel_oh = pending & (~pending + NUM_SHIFTS'(1));
    sel    = '0;
    for (int i = 0; i < NUM_SHIFTS; i++) begin
      if (sel_oh[i]) begin
        sel = sel | SHIFT_IDX_W'(i);
      end
    end
    dir       = SHIFT_TABLE[sel];
    last_next = ((pending & ~sel_oh) == '0) || (count == CNT_W'(MAX_IMAGES - 1));
  end

  pbig_axis_unit u_axis (
    .axis       (axis),
    .dir        (dir),
    .pos        (pos_q[axis]),
    .frac       (frac_q[axis]),
    .row_a_comp (row_comp(cell_row_a, axis)),
    .row_b_comp (row_comp(cell_row_b, axis)),
    .row_c_comp (row_comp(cell_row_c, axis)),
    .img_pos    (unit_pos),
    .img_frac   (unit_frac)
  );

  // control and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      enable         <= 1'b0;
      edge_threshold <= THR_RESET;
      cell_row_a     <= '0;
      cell_row_b     <= '0;
      cell_row_c     <= '0;
      next_image_id  <= ID_RESET;
      state          <= ST_IDLE;
      pending        <= '0;
      count          <= '0;
      axis           <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (push_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            pending <= skip ? '0 : take;
            count   <= '0;
            axis    <= '0;
            if (!skip) begin
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          if (pending == '0) begin
            state <= ST_IDLE;
          end else if (axis == LAST_AXIS) begin
            axis  <= '0;
            state <= ST_PUSH;
          end else begin
            axis <= axis + AXIS_W'(1);
          end
        end
        ST_PUSH: begin
          if (push_go) begin
            next_image_id <= next_image_id + ID_W'(1);
            count         <= count + CNT_W'(1);
            pending       <= last_next ? '0 : (pending & ~sel_oh);
            state         <= last_next ? ST_IDLE : ST_CALC;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE:    enable         <= cfg_data[0];
          REG_THRESHOLD: edge_threshold <= cfg_data[THR_W-1:0];
          REG_ROW_A:     cell_row_a     <= cfg_data[ROW_W-1:0];
          REG_ROW_B:     cell_row_b     <= cfg_data[ROW_W-1:0];
          REG_ROW_C:     cell_row_c     <= cfg_data[ROW_W-1:0];
          REG_FIRST_ID:  next_image_id  <= cfg_data[ID_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      src_id    <= atom_id;
      pos_q[0]  <= pos_x;
      pos_q[1]  <= pos_y;
      pos_q[2]  <= pos_z;
      frac_q[0] <= cell_frac_a;
      frac_q[1] <= cell_frac_b;
      frac_q[2] <= cell_frac_c;
    end
    if (state == ST_CALC) begin
      img_pos_q[axis]  <= unit_pos;
      img_frac_q[axis] <= unit_frac;
    end
    if (push_go) begin
      image_id     <= next_image_id;
      source_id    <= src_id;
      image_x      <= img_pos_q[0];
      image_y      <= img_pos_q[1];
      image_z      <= img_pos_q[2];
      image_frac_a <= img_frac_q[0];
      image_frac_b <= img_frac_q[1];
      image_frac_c <= img_frac_q[2];
      last_image   <= last_next;
    end
  end

endmodule

>>> src/pbig_axis_unit.sv
// ----------------------------------------------------------------------------
// pbig_axis_unit
// shared arithmetic for one axis of an image: position plus signed cell rows,
// fraction plus integer shift, both saturated
// ----------------------------------------------------------------------------
module pbig_axis_unit import pbig_pkg::*; (
  input  logic [AXIS_W-1:0]       axis,
  input  shift_dir_t              dir,
  input  logic signed [POS_W-1:0] pos,
  input  logic signed [FRAC_W-1:0] frac,
  input  logic signed [POS_W-1:0] row_a_comp,
  input  logic signed [POS_W-1:0] row_b_comp,
  input  logic signed [POS_W-1:0] row_c_comp,
  output logic signed [POS_W-1:0] img_pos,
  output logic signed [FRAC_W-1:0] img_frac
);

  localparam int SUM_W  = POS_W + 3;
  localparam int FSUM_W = FRAC_W + 2;
  localparam int POS_HI_I  = (1 << (COORD_WIDTH - 1)) - 1;
  localparam int FRAC_HI_I = (1 << (FRAC_W - 1)) - 1;
  localparam logic signed [SUM_W-1:0]  POS_HI  = SUM_W'(POS_HI_I);
  localparam logic signed [SUM_W-1:0]  POS_LO  = SUM_W'(-POS_HI_I - 1);
  localparam logic signed [FSUM_W-1:0] FRAC_HI = FSUM_W'(FRAC_HI_I);
  localparam logic signed [FSUM_W-1:0] FRAC_LO = FSUM_W'(-FRAC_HI_I - 1);
  localparam logic signed [FSUM_W-1:0] F_ONE   = FSUM_W'(FRAC_ONE);

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sum_sat;
  logic signed [FSUM_W-1:0] fsum;
  logic signed [FSUM_W-1:0] fsum_sat;

  function automatic logic signed [SUM_W-1:0] term(
    input logic signed [POS_W-1:0] v,
    input logic                    p,
    input logic                    n
  );
    logic signed [SUM_W-1:0] e;
    e = $signed({{(SUM_W-POS_W){v[POS_W-1]}}, v});
    if (p) begin
      return e;
    end else if (n) begin
      return -e;
    end else begin
      return '0;
    end
  endfunction

  always_comb begin
    sum = $signed({{(SUM_W-POS_W){pos[POS_W-1]}}, pos})
        + term(row_a_comp, dir.pos[0], dir.neg[0])
        + term(row_b_comp, dir.pos[1], dir.neg[1])
        + term(row_c_comp, dir.pos[2], dir.neg[2]);
    if (sum > POS_HI) begin
      sum_sat = POS_HI;
    end else if (sum < POS_LO) begin
      sum_sat = POS_LO;
    end else begin
      sum_sat = sum;
    end

    fsum = $signed({{(FSUM_W-FRAC_W){frac[FRAC_W-1]}}, frac});
    if (dir.pos[axis]) begin
      fsum = fsum + F_ONE;
    end else if (dir.neg[axis]) begin
      fsum = fsum - F_ONE;
    end
    if (fsum > FRAC_HI) begin
      fsum_sat = FRAC_HI;
    end else if (fsum < FRAC_LO) begin
      fsum_sat = FRAC_LO;
    end else begin
      fsum_sat = fsum;
    end
  end

  assign img_pos  = sum_sat[POS_W-1:0];
  assign img_frac = fsum_sat[FRAC_W-1:0];

endmodule

>>> src/pbig_checker.sv
// ----------------------------------------------------------------------------
// pbig_checker
// port level checks on the image generator, bound to the top level
// ----------------------------------------------------------------------------
`include "periodic_boundary_image_generator_assert.svh"

module pbig_checker import pbig_pkg::*; (
  input logic            clk,
  input logic            rst,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [ID_W-1:0] image_id,
  input logic            last_image
);

  // a waiting beat keeps its id and marker
  `PBIG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(image_id) && $stable(last_image), "image beat changed while stalled")

  // with more images of this atom to come the block stays busy
  `PBIG_ASSERT_SAME(a_busy_mid_atom, out_valid && !last_image, !in_ready, "input taken before the atom's last image")

  // output register comes out of reset empty
  `PBIG_ASSERT_SAME(a_empty_after_rst, $past(rst), !out_valid, "image beat shown straight after reset")

endmodule

bind periodic_boundary_image_generator pbig_checker u_pbig_checker (.*);
